// File: hdl/median_of_two_sorted_arrays_core_macros.svh
// assertion helpers shared by the rtl files
`ifndef MEDIAN_OF_TWO_SORTED_ARRAYS_CORE_MACROS_SVH
`define MEDIAN_OF_TWO_SORTED_ARRAYS_CORE_MACROS_SVH

// same-cycle implication
`define MSA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msa: same-cycle check failed");

// next-cycle implication
`define MSA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msa: next-cycle check failed");

`endif

// File: hdl/msa_pkg.sv
package msa_pkg;

   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned MedianWidth = 33;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_APPEND_FIRST  = 2'd0;
   localparam opcode_type OP_APPEND_SECOND = 2'd1;
   localparam opcode_type OP_COMPUTE       = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_NEIGH_HI,
      S_NEIGH_END,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_APPEND,
      DP_START,
      DP_ISSUE_MID,
      DP_UPDATE,
      DP_ISSUE_LO,
      DP_ISSUE_HI,
      DP_TAKE_HI,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      to_second;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic search_done;
      logic out_busy;
   } dp_status_type;

endpackage

// File: hdl/msa_if.sv
interface msa_req_if
   import msa_pkg::*;
();
   logic                         valid;
   logic                         ready;
   opcode_type                   opcode;
   logic signed [ValueWidth-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface msa_rsp_if
   import msa_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [MedianWidth-1:0] median_doubled;
   logic                          empty_flag;
   logic                          overflow_flag;

   modport source (output valid, output median_doubled, output empty_flag,
                   output overflow_flag, input ready);
   modport sink (input valid, input median_doubled, input empty_flag,
                 input overflow_flag, output ready);
endinterface

// File: hdl/msa_ctrl.sv
`include "median_of_two_sorted_arrays_core_macros.svh"

module msa_ctrl
   import msa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  opcode_type    req_opcode,
   output logic          req_ready,
   input  dp_status_type status_i,
   output dp_cmd_type    cmd_o
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd_o.op        = DP_NOP;
      cmd_o.to_second = 1'b0;
      req_ready       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  OP_APPEND_FIRST: begin
                     cmd_o.op = DP_APPEND;
                  end
                  OP_APPEND_SECOND: begin
                     cmd_o.op        = DP_APPEND;
                     cmd_o.to_second = 1'b1;
                  end
                  OP_COMPUTE: begin
                     cmd_o.op = DP_START;
                     state_in = S_SEARCH;
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            if (status_i.empty) begin
               state_in = S_DONE;
            end else if (!status_i.search_done) begin
               cmd_o.op = DP_ISSUE_MID;
               state_in = S_COMPARE;
            end else begin
               cmd_o.op = DP_ISSUE_LO;
               state_in = S_NEIGH_HI;
            end
         end
         S_COMPARE: begin
            cmd_o.op = DP_UPDATE;
            state_in = S_SEARCH;
         end
         S_NEIGH_HI: begin
            cmd_o.op = DP_ISSUE_HI;
            state_in = S_NEIGH_END;
         end
         S_NEIGH_END: begin
            cmd_o.op = DP_TAKE_HI;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!status_i.out_busy) begin
               cmd_o.op = DP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `MSA_ASSERT_NXT(a_start_to_search, clock, reset, cmd_o.op == DP_START, state_ff == S_SEARCH)
   `MSA_ASSERT_NXT(a_compare_returns, clock, reset, state_ff == S_COMPARE, state_ff == S_SEARCH)
   `MSA_ASSERT_IMP(a_emit_when_free, clock, reset, cmd_o.op == DP_EMIT, !status_i.out_busy)

endmodule

// File: hdl/msa_dp.sv
`include "median_of_two_sorted_arrays_core_macros.svh"

module msa_dp
   import msa_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd_i,
   output dp_status_type                 status_o,
   input  logic signed [ValueWidth-1:0]  req_value,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [MedianWidth-1:0] rsp_median_doubled,
   output logic                          rsp_empty_flag,
   output logic                          rsp_overflow_flag
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // element stores
   logic [ValueWidth-1:0] mem1 [DEPTH];
   logic [ValueWidth-1:0] mem2 [DEPTH];
   logic [ValueWidth-1:0] rd1_ff;
   logic [ValueWidth-1:0] rd2_ff;

   logic [CW-1:0] cnt1_ff, cnt1_in;
   logic [CW-1:0] cnt2_ff, cnt2_in;
   logic          dropped_ff, dropped_in;

   // search context
   logic          swap_ff;
   logic [CW-1:0] na_ff;
   logic [CW-1:0] nb_ff;
   logic [CW-1:0] half_ff;
   logic [CW-1:0] low_ff;
   logic [CW-1:0] high_ff;
   logic [CW-1:0] mid_ff;
   logic          odd_ff;
   logic          empty_ff;
   logic          ovf_ff;
   logic signed [ValueWidth-1:0] a_ff;
   logic signed [ValueWidth-1:0] b_ff;

   logic                          rsp_valid_ff;
   logic signed [MedianWidth-1:0] rsp_median_ff;
   logic                          rsp_empty_ff;
   logic                          rsp_ovf_ff;

   logic [CW:0]   n_c;
   logic [CW:0]   nm1_c;
   logic [CW-1:0] half_c;
   logic [CW-1:0] na_c;
   logic [CW-1:0] nb_c;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid_c;
   logic [CW:0]   hl1_c;
   logic [CW-1:0] s_idx;
   logic [CW-1:0] l_idx;
   logic [AW-1:0] addr1;
   logic [AW-1:0] addr2;
   logic signed [ValueWidth-1:0] sd;
   logic signed [ValueWidth-1:0] ld;
   logic          have_l_lo;
   logic          have_l_hi;
   logic          have_s_lo;
   logic          have_s_hi;
   logic signed [ValueWidth-1:0] a_c;
   logic signed [ValueWidth-1:0] b_c;
   logic signed [MedianWidth-1:0] a_ext;
   logic signed [MedianWidth-1:0] b_ext;
   logic signed [MedianWidth-1:0] median_c;

   assign n_c     = {1'b0, cnt1_ff} + {1'b0, cnt2_ff};
   assign nm1_c   = (n_c - 1'b1) >> 1;
   assign half_c  = nm1_c[CW-1:0];
   assign na_c    = (cnt1_ff > cnt2_ff) ? cnt2_ff : cnt1_ff;
   assign nb_c    = (cnt1_ff > cnt2_ff) ? cnt1_ff : cnt2_ff;
   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_c   = mid_sum[CW:1];
   assign hl1_c   = {1'b0, half_ff} - {1'b0, low_ff} + 1'b1;

   always_comb begin
      s_idx = '0;
      l_idx = '0;
      case (cmd_i.op)
         DP_ISSUE_MID: begin
            s_idx = mid_c;
            l_idx = half_ff - mid_c;
         end
         DP_ISSUE_LO: begin
            s_idx = low_ff - 1'b1;
            l_idx = half_ff - low_ff;
         end
         DP_ISSUE_HI: begin
            s_idx = low_ff;
            l_idx = hl1_c[CW-1:0];
         end
         default: ;
      endcase
   end

   // the shorter array sits in whichever store the swap bit says
   assign addr1 = swap_ff ? l_idx[AW-1:0] : s_idx[AW-1:0];
   assign addr2 = swap_ff ? s_idx[AW-1:0] : l_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd_i.op == DP_APPEND && !cmd_i.to_second && cnt1_ff < CW'(DEPTH)) begin
         mem1[cnt1_ff[AW-1:0]] <= req_value;
      end
      rd1_ff <= mem1[addr1];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.op == DP_APPEND && cmd_i.to_second && cnt2_ff < CW'(DEPTH)) begin
         mem2[cnt2_ff[AW-1:0]] <= req_value;
      end
      rd2_ff <= mem2[addr2];
   end

   assign sd = swap_ff ? $signed(rd2_ff) : $signed(rd1_ff);
   assign ld = swap_ff ? $signed(rd1_ff) : $signed(rd2_ff);

   // missing neighbours drop out of the max on the low side, the min on the high side
   assign have_l_lo = (half_ff - low_ff) < nb_ff;
   assign have_s_lo = low_ff != '0;
   assign have_l_hi = hl1_c < {1'b0, nb_ff};
   assign have_s_hi = low_ff < na_ff;
   assign a_c = (have_s_lo && (!have_l_lo || sd > ld)) ? sd : ld;
   assign b_c = (have_s_hi && (!have_l_hi || sd < ld)) ? sd : ld;

   assign a_ext    = {a_ff[ValueWidth-1], a_ff};
   assign b_ext    = {b_ff[ValueWidth-1], b_ff};
   assign median_c = empty_ff ? '0 : (odd_ff ? a_ext + a_ext : a_ext + b_ext);

   always_comb begin
      cnt1_in    = cnt1_ff;
      cnt2_in    = cnt2_ff;
      dropped_in = dropped_ff;
      case (cmd_i.op)
         DP_APPEND: begin
            if (!cmd_i.to_second) begin
               if (cnt1_ff < CW'(DEPTH)) begin
                  cnt1_in = cnt1_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end else begin
               if (cnt2_ff < CW'(DEPTH)) begin
                  cnt2_in = cnt2_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         DP_START: begin
            cnt1_in    = '0;
            cnt2_in    = '0;
            dropped_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt1_ff    <= cnt1_in;
         cnt2_ff    <= cnt2_in;
         dropped_ff <= dropped_in;
         if (cmd_i.op == DP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd_i.op)
         DP_START: begin
            swap_ff  <= cnt1_ff > cnt2_ff;
            na_ff    <= na_c;
            nb_ff    <= nb_c;
            half_ff  <= half_c;
            low_ff   <= '0;
            high_ff  <= (half_c > na_c) ? na_c : half_c;
            odd_ff   <= n_c[0];
            empty_ff <= n_c == '0;
            ovf_ff   <= dropped_ff;
         end
         DP_ISSUE_MID: begin
            mid_ff <= mid_c;
         end
         DP_UPDATE: begin
            if (sd < ld) begin
               low_ff <= mid_ff + 1'b1;
            end else begin
               high_ff <= mid_ff;
            end
         end
         DP_ISSUE_HI: begin
            a_ff <= a_c;
         end
         DP_TAKE_HI: begin
            b_ff <= b_c;
         end
         DP_EMIT: begin
            rsp_median_ff <= median_c;
            rsp_empty_ff  <= empty_ff;
            rsp_ovf_ff    <= ovf_ff;
         end
         default: ;
      endcase
   end

   assign status_o.empty       = empty_ff;
   assign status_o.search_done = !(low_ff < high_ff);
   assign status_o.out_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = rsp_median_ff;
   assign rsp_empty_flag     = rsp_empty_ff;
   assign rsp_overflow_flag  = rsp_ovf_ff;

   `MSA_ASSERT_NXT(a_low_le_high, clock, reset, cmd_i.op == DP_UPDATE, low_ff <= high_ff)
   `MSA_ASSERT_IMP(a_mid_below_high, clock, reset, cmd_i.op == DP_ISSUE_MID, mid_c < high_ff)
   `MSA_ASSERT_IMP(a_empty_is_zero, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_median_ff == '0)

endmodule

// File: hdl/median_of_two_sorted_arrays_core.sv
// Median of two ascending arrays of signed 32-bit values, reported doubled so no
// fraction is lost. Opcode 0 appends a beat's value to the first array, opcode 1
// to the second; appends are accepted back to back, also while an earlier result
// waits on the output. An append to a full array (DEPTH entries) is dropped and
// reported by overflow_flag of the next result. Opcode 2 returns one result beat
// and clears both arrays; opcode 3 is swallowed. A compute binary-searches the
// shorter array; each probe is a registered read of both element memories
// followed by a compare step, and input is held off meanwhile. Two empty arrays
// give empty_flag with a zero median.
module median_of_two_sorted_arrays_core
   import msa_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input logic   clock,
   input logic   reset,
   msa_req_if.sink   req_bus,
   msa_rsp_if.source rsp_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;

   msa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .status_i   (status),
      .cmd_o      (cmd)
   );

   msa_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd_i              (cmd),
      .status_o           (status),
      .req_value          (req_bus.value),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_median_doubled (rsp_bus.median_doubled),
      .rsp_empty_flag     (rsp_bus.empty_flag),
      .rsp_overflow_flag  (rsp_bus.overflow_flag)
   );

endmodule
